// ===== hdl/gif_lzw_decoder_core_assert.svh =====
// Assertion macros for the GIF LZW decoder core checker.
`ifndef GIF_LZW_DECODER_CORE_ASSERT_SVH
`define GIF_LZW_DECODER_CORE_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define GLD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define GLD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/gld_pkg.sv =====
// Shared constants and types of the GIF LZW decoder core.
package gld_pkg;
  localparam int TABLE_DEPTH   = 4096;
  localparam int MAX_CODE_BITS = 12;
  localparam int ADDR_W        = 12;
  localparam int CNT_W         = 13;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_PULL    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [2:0] ST_PIXEL     = 3'd0;
  localparam logic [2:0] ST_NEED      = 3'd1;
  localparam logic [2:0] ST_END       = 3'd2;
  localparam logic [2:0] ST_ACCEPTED  = 3'd3;
  localparam logic [2:0] ST_REFUSED   = 3'd4;
  localparam logic [2:0] ST_RESTARTED = 3'd5;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_ACCEPT, CMD_PULL, CMD_WALK, CMD_STORE, CMD_ADD, CMD_POP
  } cmd_e;

  typedef enum logic [1:0] {NX_DONE, NX_POP, NX_AGAIN, NX_WALK} next_e;

  typedef struct packed {
    next_e pull_next;
    logic  walk_more;
    logic  out_free;
  } dp_status_t;
endpackage

// ===== hdl/gld_datapath.sv =====
// Datapath: bit accumulator, code tables, pixel stack and result register.
module gld_datapath
  import gld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_e        cmd_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  byte_i,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  out_pixel_o,
  output logic [2:0]  out_status_o,
  output dp_status_t  status_o
);
  logic [3:0]        min_q;
  logic [31:0]       acc_q, acc_d;
  logic [5:0]        bits_q, bits_d;
  logic [7:0]        left_q, left_d;
  logic [3:0]        cw_q, cw_d;
  logic [3:0]        root_q, root_d;
  logic [CNT_W-1:0]  nfc_q, nfc_d;
  logic [ADDR_W-1:0] prev_q, prev_d;
  logic              aclr_q, aclr_d;
  logic              ended_q, ended_d;
  logic [CNT_W-1:0]  sc_q, sc_d;
  logic [ADDR_W-1:0] c_q, c_d;
  logic [ADDR_W-1:0] code_q, code_d;
  logic              kw_q, kw_d;
  logic [7:0]        first_q, first_d;
  logic              ov_q, ov_d;
  logic [7:0]        opix_q, opix_d;
  logic [2:0]        ost_q, ost_d;

  logic [ADDR_W-1:0] prefix_mem [TABLE_DEPTH];
  logic [7:0]        suffix_mem [TABLE_DEPTH];
  logic [7:0]        stack_mem  [TABLE_DEPTH];
  logic [ADDR_W-1:0] prefix_rd_q;
  logic [7:0]        suffix_rd_q, stack_rd_q;

  logic              tbl_we, stk_we;
  logic [ADDR_W-1:0] tbl_wa, stk_wa, stk_ra, tbl_ra;
  logic [7:0]        stk_wd;

  logic [3:0]        sat_size;
  logic [ADDR_W-1:0] clear_code, code;
  logic [CNT_W-1:0]  nfc_inc;
  logic              more;

  assign sat_size   = (min_q < 4'd1) ? 4'd1 : ((min_q > 4'd8) ? 4'd8 : min_q);
  assign clear_code = ADDR_W'(1) << root_q;
  assign code       = acc_q[ADDR_W-1:0] & ~({ADDR_W{1'b1}} << cw_q);
  assign more       = (c_q >= clear_code) && (sc_q < CNT_W'(TABLE_DEPTH));
  assign nfc_inc    = (nfc_q < CNT_W'(TABLE_DEPTH)) ? nfc_q + CNT_W'(1) : nfc_q;

  always_comb begin
    acc_d = acc_q; bits_d = bits_q; left_d = left_q; cw_d = cw_q; root_d = root_q;
    nfc_d = nfc_q; prev_d = prev_q; aclr_d = aclr_q; ended_d = ended_q;
    sc_d = sc_q; c_d = c_q; code_d = code_q; kw_d = kw_q; first_d = first_q;
    ov_d = ov_q && !out_ready_i; opix_d = opix_q; ost_d = ost_q;
    tbl_we = 1'b0; stk_we = 1'b0;
    tbl_wa = nfc_q[ADDR_W-1:0]; stk_wa = sc_q[ADDR_W-1:0]; stk_wd = c_q[7:0];
    stk_ra = sc_q[ADDR_W-1:0] - ADDR_W'(1); tbl_ra = c_q;
    status_o.pull_next = NX_DONE;
    status_o.walk_more = more;
    status_o.out_free  = !ov_q || out_ready_i;
    case (cmd_i)
      CMD_ACCEPT: begin
        ov_d = 1'b1; opix_d = 8'd0; ost_d = ST_REFUSED;
        case (op_i)
          OP_PUSH: begin
            if (ended_q) begin
              ost_d = ST_REFUSED;
            end else if (left_q == 8'd0) begin
              ost_d = ST_ACCEPTED;
              if (byte_i == 8'd0) ended_d = 1'b1;
              else left_d = byte_i;
            end else if (bits_q > 6'd24) begin
              ost_d = ST_REFUSED;
            end else begin
              ost_d  = ST_ACCEPTED;
              acc_d  = acc_q | ({24'd0, byte_i} << bits_q);
              bits_d = bits_q + 6'd8;
              left_d = left_q - 8'd1;
            end
          end
          OP_PULL: ov_d = ov_q && !out_ready_i;
          OP_RESTART: begin
            ost_d = ST_RESTARTED;
            sc_d = '0; acc_d = '0; bits_d = '0; left_d = '0; prev_d = '0;
            aclr_d = 1'b0; ended_d = 1'b0;
            root_d = sat_size; cw_d = sat_size + 4'd1;
            nfc_d = (CNT_W'(1) << sat_size) + CNT_W'(2);
          end
          default: ost_d = ST_REFUSED;
        endcase
      end
      CMD_PULL: begin
        if (sc_q != '0) begin
          sc_d = sc_q - CNT_W'(1);
          status_o.pull_next = NX_POP;
        end else if (bits_q < {2'b00, cw_q}) begin
          ov_d = 1'b1; opix_d = 8'd0; ost_d = ended_q ? ST_END : ST_NEED;
        end else begin
          acc_d  = acc_q >> cw_q;
          bits_d = bits_q - {2'b00, cw_q};
          code_d = code;
          if (code == clear_code) begin
            root_d = sat_size; cw_d = sat_size + 4'd1;
            nfc_d = (CNT_W'(1) << sat_size) + CNT_W'(2);
            aclr_d = 1'b1;
            status_o.pull_next = NX_AGAIN;
          end else if ((code == clear_code + ADDR_W'(1)) ||
                       (aclr_q && code >= clear_code) ||
                       (!aclr_q && ({1'b0, code} > nfc_q ||
                        ({1'b0, code} == nfc_q && nfc_q >= CNT_W'(TABLE_DEPTH))))) begin
            ended_d = 1'b1; acc_d = '0; bits_d = '0;
            ov_d = 1'b1; opix_d = 8'd0; ost_d = ST_END;
          end else if (aclr_q) begin
            aclr_d = 1'b0; prev_d = code;
            ov_d = 1'b1; opix_d = code[7:0]; ost_d = ST_PIXEL;
          end else if ({1'b0, code} < nfc_q) begin
            c_d = code; kw_d = 1'b0;
            status_o.pull_next = NX_WALK;
          end else begin
            sc_d = CNT_W'(1); c_d = prev_q; kw_d = 1'b1;
            status_o.pull_next = NX_WALK;
          end
        end
      end
      CMD_WALK: begin
        if (!more) begin
          first_d = c_q[7:0];
          if (sc_q < CNT_W'(TABLE_DEPTH)) begin
            stk_we = 1'b1; stk_wd = c_q[7:0]; sc_d = sc_q + CNT_W'(1);
          end
        end
      end
      CMD_STORE: begin
        stk_we = 1'b1; stk_wd = suffix_rd_q;
        sc_d = sc_q + CNT_W'(1); c_d = prefix_rd_q;
      end
      CMD_ADD: begin
        if (kw_q) begin
          stk_we = 1'b1; stk_wa = '0; stk_wd = first_q;
        end
        tbl_we = nfc_q < CNT_W'(TABLE_DEPTH);
        nfc_d = nfc_inc;
        if (nfc_inc >= (CNT_W'(1) << cw_q) && cw_q < 4'(MAX_CODE_BITS)) cw_d = cw_q + 4'd1;
        prev_d = code_q;
      end
      CMD_POP: begin
        ov_d = 1'b1; opix_d = stack_rd_q; ost_d = ST_PIXEL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= 4'd8; acc_q <= '0; bits_q <= '0; left_q <= '0;
      root_q <= 4'd8; cw_q <= 4'd9; nfc_q <= CNT_W'(258); prev_q <= '0;
      aclr_q <= 1'b0; ended_q <= 1'b0; sc_q <= '0; ov_q <= 1'b0;
      kw_q <= 1'b0;
    end else begin
      if (cfg_we_i) min_q <= cfg_data_i;
      acc_q <= acc_d; bits_q <= bits_d; left_q <= left_d; root_q <= root_d;
      cw_q <= cw_d; nfc_q <= nfc_d; prev_q <= prev_d; aclr_q <= aclr_d;
      ended_q <= ended_d; sc_q <= sc_d; ov_q <= ov_d; kw_q <= kw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; code_q <= code_d; first_q <= first_d;
    opix_q <= opix_d; ost_q <= ost_d;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      prefix_mem[tbl_wa] <= prev_q;
      suffix_mem[tbl_wa] <= first_q;
    end
    prefix_rd_q <= prefix_mem[tbl_ra];
    suffix_rd_q <= suffix_mem[tbl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stack_rd_q <= stack_mem[stk_ra];
  end

  assign out_valid_o  = ov_q;
  assign out_pixel_o  = opix_q;
  assign out_status_o = ost_q;
endmodule

// ===== hdl/gld_controller.sv =====
// Controller state machine sequencing requests through the datapath.
module gld_controller
  import gld_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] op_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output cmd_e       cmd_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PULL  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_POP   = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o = CMD_ACCEPT;
          if (op_i == OP_PULL) state_d = S_PULL;
        end
      end
      S_PULL: begin
        cmd_o = CMD_PULL;
        case (status_i.pull_next)
          NX_POP:   state_d = S_POP;
          NX_AGAIN: state_d = S_PULL;
          NX_WALK:  state_d = S_WALK;
          default:  state_d = S_IDLE;
        endcase
      end
      S_WALK: begin
        cmd_o   = CMD_WALK;
        state_d = status_i.walk_more ? S_STORE : S_ADD;
      end
      S_STORE: begin
        cmd_o = CMD_STORE; state_d = S_WALK;
      end
      S_ADD: begin
        cmd_o = CMD_ADD; state_d = S_PULL;
      end
      S_POP: begin
        cmd_o = CMD_POP; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== hdl/gif_lzw_decoder_core.sv =====
// Push, restart and unknown requests answer in the cycle after acceptance.
// A pull answers from a stacked pixel through the pull and pop states, or with a need/end
// status; a decoded code walks its prefix chain through the walk and store states.
// A clear repeats the pull state; one request is taken at a time, only in the idle state.
// Reset (rst_ni low, asynchronous) empties the stack and accumulator, sets size 8.
// Tables and pixel stack hold no reset value; they are written before being read.
module gif_lzw_decoder_core
  import gld_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0] s_axis_tuser,   // [1:0] opcode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] pixel
  output logic [2:0] m_axis_tuser,   // [2:0] status
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i      // min_code_size
);
  cmd_e       cmd;
  dp_status_t status;

  // Configuration writes are always taken; the host must make writes only when idle.
  assign cfg_ready_o = 1'b1;

  // Sequence each request: accept, then step the pull through decode states.
  gld_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .op_i       (s_axis_tuser),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  // Hold all decoder state, the tables, the stack and the result register.
  gld_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (s_axis_tuser),
    .byte_i       (s_axis_tdata),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_pixel_o  (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .status_o     (status)
  );
endmodule

// ===== hdl/gld_checker.sv =====
// Port-level checker for the GIF LZW decoder core, bound to the top level.
`include "gif_lzw_decoder_core_assert.svh"
module gld_checker
  import gld_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser
);
  `GLD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `GLD_ASSERT_NOW(a_pixel_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ST_PIXEL), m_axis_tdata == 8'd0, "non-pixel result carries data")
  `GLD_ASSERT_NOW(a_ready_free, clk_i, rst_ni, s_axis_tready, !m_axis_tvalid || m_axis_tready, "request taken while result pending")
  `GLD_ASSERT_NEXT(a_push_ans, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_PUSH), m_axis_tvalid && ((m_axis_tuser == ST_ACCEPTED) || (m_axis_tuser == ST_REFUSED)), "push not answered next cycle")
endmodule

bind gif_lzw_decoder_core gld_checker u_gld_checker (.*);
